// File: sv/mbph_pkg.sv
// Shared types, constants and codes for the meter ballistics block.
`default_nettype none

package mbph_pkg;

  // Width of every stored value and of the narrow output fields.
  localparam int VAL_W = 21;
  localparam int NARROW_W = 17;

  // Default width of the rate registers.
  localparam int DEF_RATE_BITS = 8;

  // Reset values of the rate registers, before masking to the register width.
  localparam int ATTACK_RST = 77;
  localparam int FALL_RST = 26;
  localparam int PEAK_FALL_RST = 13;

  typedef logic [VAL_W-1:0] val_t;

  // Channel ranges.
  localparam val_t FWD_MAX = val_t'(1500000);
  localparam val_t REF_MAX = val_t'(100000);
  localparam val_t TEMP_MAX = val_t'(100000);
  localparam val_t SWR_MIN = val_t'(1000);

  // Smallest step for shown values.
  localparam val_t FWD_MIN_STEP = val_t'(2000);
  localparam val_t REF_MIN_STEP = val_t'(200);
  localparam val_t SWR_MIN_STEP = val_t'(10);
  localparam val_t TEMP_MIN_STEP = val_t'(200);

  // Smallest step for peak markers.
  localparam val_t FWD_PEAK_MIN_STEP = val_t'(1000);
  localparam val_t REF_PEAK_MIN_STEP = val_t'(100);
  localparam val_t SWR_PEAK_MIN_STEP = val_t'(5);

  // Command codes.
  localparam logic [2:0] CMD_FWD = 3'd0;
  localparam logic [2:0] CMD_REF = 3'd1;
  localparam logic [2:0] CMD_SWR = 3'd2;
  localparam logic [2:0] CMD_TEMP = 3'd3;
  localparam logic [2:0] CMD_TICK = 3'd4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_FALL = 2'd2;

  // Status of one lane for one tick.
  typedef struct packed {
    logic chg;
    logic moving;
  } lane_stat_t;

  // All architectural state that a request can change.
  typedef struct packed {
    val_t fwd_target;
    val_t ref_target;
    val_t swr_target;
    val_t temp_target;
    val_t fwd_shown;
    val_t ref_shown;
    val_t swr_shown;
    val_t temp_shown;
    val_t fwd_peak;
    val_t ref_peak;
    val_t swr_peak;
    logic running;
  } meter_state_t;

  // One result as it is held in the output register.
  typedef struct packed {
    logic [VAL_W-1:0] forward_display;
    logic [NARROW_W-1:0] reflected_display;
    logic [VAL_W-1:0] swr_display;
    logic [NARROW_W-1:0] temp_display;
    logic [VAL_W-1:0] forward_peak_out;
    logic [NARROW_W-1:0] reflected_peak_out;
    logic [VAL_W-1:0] swr_peak_out;
    logic animating;
    logic changed;
  } result_t;

endpackage

`default_nettype wire

// File: sv/mbph_in_if.sv
// Input channel interface: command and sample value with valid/ready.
`default_nettype none

interface mbph_in_if;
  logic valid;
  logic ready;
  logic [2:0] cmd;
  logic [20:0] sample_value;

  modport source (output valid, output cmd, output sample_value, input ready);
  modport sink (input valid, input cmd, input sample_value, output ready);
endinterface

`default_nettype wire

// File: sv/mbph_out_if.sv
// Result channel interface: shown values, peak markers and flags with valid/ready.
`default_nettype none

interface mbph_out_if;
  logic valid;
  logic ready;
  logic [20:0] forward_display;
  logic [16:0] reflected_display;
  logic [20:0] swr_display;
  logic [16:0] temp_display;
  logic [20:0] forward_peak_out;
  logic [16:0] reflected_peak_out;
  logic [20:0] swr_peak_out;
  logic animating;
  logic changed;

  modport source (
    output valid, output forward_display, output reflected_display, output swr_display,
    output temp_display, output forward_peak_out, output reflected_peak_out,
    output swr_peak_out, output animating, output changed, input ready
  );
  modport sink (
    input valid, input forward_display, input reflected_display, input swr_display,
    input temp_display, input forward_peak_out, input reflected_peak_out,
    input swr_peak_out, input animating, input changed, output ready
  );
endinterface

`default_nettype wire

// File: sv/mbph_shown_lane.sv
// One tick of attack/decay movement of a shown value toward its target.
`default_nettype none

module mbph_shown_lane #(
  parameter int RATE_BITS = mbph_pkg::DEF_RATE_BITS
) (
  input  mbph_pkg::val_t       cur_i,
  input  mbph_pkg::val_t       target_i,
  input  mbph_pkg::val_t       min_step_i,
  input  logic [RATE_BITS-1:0] up_rate_i,
  input  logic [RATE_BITS-1:0] down_rate_i,
  output mbph_pkg::val_t       nxt_o,
  output mbph_pkg::lane_stat_t stat_o
);
  import mbph_pkg::*;

  logic                       rising;
  val_t                       span;
  logic [RATE_BITS-1:0]       rate;
  logic [VAL_W+RATE_BITS-1:0] prod;
  val_t                       frac;
  val_t                       step;

  // Distance and the rate that applies in this direction.
  assign rising = cur_i < target_i;
  assign span   = rising ? (target_i - cur_i) : (cur_i - target_i);
  assign rate   = rising ? up_rate_i : down_rate_i;

  // Truncated fraction of the distance, no smaller than the minimum step.
  assign prod = {{RATE_BITS{1'b0}}, span} * {{VAL_W{1'b0}}, rate};
  assign frac = prod[VAL_W+RATE_BITS-1:RATE_BITS];
  assign step = (frac > min_step_i) ? frac : min_step_i;

  // Move, never passing the target; a short distance snaps without keeping the meter busy.
  always_comb begin
    if (span < min_step_i) begin
      nxt_o         = target_i;
      stat_o.chg    = cur_i != target_i;
      stat_o.moving = 1'b0;
    end else begin
      if (step >= span) begin
        nxt_o = target_i;
      end else if (rising) begin
        nxt_o = cur_i + step;
      end else begin
        nxt_o = cur_i - step;
      end
      stat_o.chg    = 1'b1;
      stat_o.moving = 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: sv/mbph_peak_lane.sv
// One tick of fall of a peak marker toward its target.
`default_nettype none

module mbph_peak_lane #(
  parameter int RATE_BITS = mbph_pkg::DEF_RATE_BITS
) (
  input  mbph_pkg::val_t       peak_i,
  input  mbph_pkg::val_t       target_i,
  input  mbph_pkg::val_t       min_step_i,
  input  logic [RATE_BITS-1:0] rate_i,
  output mbph_pkg::val_t       nxt_o,
  output mbph_pkg::lane_stat_t stat_o
);
  import mbph_pkg::*;

  logic                       above;
  val_t                       span;
  logic [VAL_W+RATE_BITS-1:0] prod;
  val_t                       frac;
  val_t                       step;

  assign above = peak_i > target_i;
  assign span  = peak_i - target_i;

  // Truncated fraction of the distance, no smaller than the minimum step.
  assign prod = {{RATE_BITS{1'b0}}, span} * {{VAL_W{1'b0}}, rate_i};
  assign frac = prod[VAL_W+RATE_BITS-1:RATE_BITS];
  assign step = (frac > min_step_i) ? frac : min_step_i;

  // Only a peak above its target falls.
  always_comb begin
    if (above) begin
      nxt_o         = (step >= span) ? target_i : (peak_i - step);
      stat_o.chg    = 1'b1;
      stat_o.moving = 1'b1;
    end else begin
      nxt_o         = peak_i;
      stat_o.chg    = 1'b0;
      stat_o.moving = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: sv/meter_ballistics_peak_hold.sv
// Top level of the four-channel meter smoother with peak hold.
//
//  Port group | Direction | Contents
//  -----------+-----------+-------------------------------------------------------
//  in_ch      | sink      | cmd, sample_value; valid/ready
//  out_ch     | source    | four shown values, three peaks, animating, changed
//  cfg_*      | write     | cfg_we, cfg_index, cfg_wdata (attack, fall, peak fall)
//
// One request is accepted in every cycle while out_ch takes its results; the request
// is captured in an input register, worked out in one pass through seven parallel
// lanes (one multiply each) and stored in the result register, from which it is
// presented.
// Reset is synchronous and returns the meter to rest with the default rates.
// While the result is not taken, one more request is held in the input register
// and then in_ch.ready falls; nothing is lost or repeated.
`default_nettype none

module meter_ballistics_peak_hold #(
  parameter int RATE_BITS = mbph_pkg::DEF_RATE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mbph_in_if.sink                           in_ch,
  mbph_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [mbph_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [RATE_BITS-1:0]              cfg_wdata
);
  import mbph_pkg::*;

  // Rate registers.
  logic [RATE_BITS-1:0] attack_rate_r;
  logic [RATE_BITS-1:0] fall_rate_r;
  logic [RATE_BITS-1:0] peak_fall_rate_r;

  // Input register.
  logic       s1_valid_r;
  logic [2:0] s1_cmd_r;
  val_t       s1_value_r;
  logic       s1_adv;
  logic       commit;

  // Result register.
  logic    out_valid_r;
  result_t out_r;
  result_t out_nxt;

  // Meter state.
  meter_state_t st_r;
  meter_state_t st_nxt;
  logic         chg_c;

  // Lane results.
  val_t       fwd_shown_mv, ref_shown_mv, swr_shown_mv, temp_shown_mv;
  val_t       fwd_peak_mv, ref_peak_mv, swr_peak_mv;
  lane_stat_t fwd_s_st, ref_s_st, swr_s_st, temp_s_st;
  lane_stat_t fwd_p_st, ref_p_st, swr_p_st;
  logic       tick_chg, tick_moving;

  // Clamped sample values.
  val_t fwd_clamp, ref_clamp, swr_clamp, temp_clamp;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_rate_r    <= RATE_BITS'(ATTACK_RST);
      fall_rate_r      <= RATE_BITS'(FALL_RST);
      peak_fall_rate_r <= RATE_BITS'(PEAK_FALL_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATTACK:    attack_rate_r    <= cfg_wdata;
        CFG_FALL:      fall_rate_r      <= cfg_wdata;
        CFG_PEAK_FALL: peak_fall_rate_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on whenever the result register is free.
  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign commit      = s1_valid_r && s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_cmd_r   <= in_ch.cmd;
      s1_value_r <= in_ch.sample_value;
    end
  end

  // Shown value lanes.
  mbph_shown_lane #(.RATE_BITS(RATE_BITS)) u_fwd_shown (
    .cur_i(st_r.fwd_shown), .target_i(st_r.fwd_target), .min_step_i(FWD_MIN_STEP),
    .up_rate_i(attack_rate_r), .down_rate_i(fall_rate_r),
    .nxt_o(fwd_shown_mv), .stat_o(fwd_s_st)
  );
  mbph_shown_lane #(.RATE_BITS(RATE_BITS)) u_ref_shown (
    .cur_i(st_r.ref_shown), .target_i(st_r.ref_target), .min_step_i(REF_MIN_STEP),
    .up_rate_i(attack_rate_r), .down_rate_i(fall_rate_r),
    .nxt_o(ref_shown_mv), .stat_o(ref_s_st)
  );
  mbph_shown_lane #(.RATE_BITS(RATE_BITS)) u_swr_shown (
    .cur_i(st_r.swr_shown), .target_i(st_r.swr_target), .min_step_i(SWR_MIN_STEP),
    .up_rate_i(attack_rate_r), .down_rate_i(fall_rate_r),
    .nxt_o(swr_shown_mv), .stat_o(swr_s_st)
  );
  mbph_shown_lane #(.RATE_BITS(RATE_BITS)) u_temp_shown (
    .cur_i(st_r.temp_shown), .target_i(st_r.temp_target), .min_step_i(TEMP_MIN_STEP),
    .up_rate_i(attack_rate_r), .down_rate_i(fall_rate_r),
    .nxt_o(temp_shown_mv), .stat_o(temp_s_st)
  );

  // Peak marker lanes.
  mbph_peak_lane #(.RATE_BITS(RATE_BITS)) u_fwd_peak (
    .peak_i(st_r.fwd_peak), .target_i(st_r.fwd_target), .min_step_i(FWD_PEAK_MIN_STEP),
    .rate_i(peak_fall_rate_r), .nxt_o(fwd_peak_mv), .stat_o(fwd_p_st)
  );
  mbph_peak_lane #(.RATE_BITS(RATE_BITS)) u_ref_peak (
    .peak_i(st_r.ref_peak), .target_i(st_r.ref_target), .min_step_i(REF_PEAK_MIN_STEP),
    .rate_i(peak_fall_rate_r), .nxt_o(ref_peak_mv), .stat_o(ref_p_st)
  );
  mbph_peak_lane #(.RATE_BITS(RATE_BITS)) u_swr_peak (
    .peak_i(st_r.swr_peak), .target_i(st_r.swr_target), .min_step_i(SWR_PEAK_MIN_STEP),
    .rate_i(peak_fall_rate_r), .nxt_o(swr_peak_mv), .stat_o(swr_p_st)
  );

  assign tick_chg = fwd_s_st.chg || ref_s_st.chg || swr_s_st.chg || temp_s_st.chg ||
                    fwd_p_st.chg || ref_p_st.chg || swr_p_st.chg;
  assign tick_moving = fwd_s_st.moving || ref_s_st.moving || swr_s_st.moving ||
                       temp_s_st.moving || fwd_p_st.moving || ref_p_st.moving ||
                       swr_p_st.moving;

  // Sample clamps to the channel ranges.
  assign fwd_clamp  = (s1_value_r > FWD_MAX) ? FWD_MAX : s1_value_r;
  assign ref_clamp  = (s1_value_r > REF_MAX) ? REF_MAX : s1_value_r;
  assign swr_clamp  = (s1_value_r < SWR_MIN) ? SWR_MIN : s1_value_r;
  assign temp_clamp = (s1_value_r > TEMP_MAX) ? TEMP_MAX : s1_value_r;

  // Next state for the request in the input register.
  always_comb begin
    st_nxt = st_r;
    chg_c  = 1'b0;
    case (s1_cmd_r)
      CMD_FWD: begin
        st_nxt.fwd_target = fwd_clamp;
        st_nxt.running    = 1'b1;
        if (fwd_clamp > st_r.fwd_peak) begin
          st_nxt.fwd_peak = fwd_clamp;
          chg_c           = 1'b1;
        end
      end
      CMD_REF: begin
        st_nxt.ref_target = ref_clamp;
        st_nxt.running    = 1'b1;
        if (ref_clamp > st_r.ref_peak) begin
          st_nxt.ref_peak = ref_clamp;
          chg_c           = 1'b1;
        end
      end
      CMD_SWR: begin
        st_nxt.swr_target = swr_clamp;
        st_nxt.running    = 1'b1;
        if (swr_clamp > st_r.swr_peak) begin
          st_nxt.swr_peak = swr_clamp;
          chg_c           = 1'b1;
        end
      end
      CMD_TEMP: begin
        st_nxt.temp_target = temp_clamp;
        st_nxt.running     = 1'b1;
      end
      CMD_TICK: begin
        if (st_r.running) begin
          st_nxt.fwd_shown  = fwd_shown_mv;
          st_nxt.ref_shown  = ref_shown_mv;
          st_nxt.swr_shown  = swr_shown_mv;
          st_nxt.temp_shown = temp_shown_mv;
          st_nxt.fwd_peak   = fwd_peak_mv;
          st_nxt.ref_peak   = ref_peak_mv;
          st_nxt.swr_peak   = swr_peak_mv;
          st_nxt.running    = tick_moving;
          chg_c             = tick_chg;
        end
      end
      default: ;
    endcase
  end

  // State is updated as the request passes into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.fwd_target  <= '0;
      st_r.ref_target  <= '0;
      st_r.swr_target  <= SWR_MIN;
      st_r.temp_target <= '0;
      st_r.fwd_shown   <= '0;
      st_r.ref_shown   <= '0;
      st_r.swr_shown   <= SWR_MIN;
      st_r.temp_shown  <= '0;
      st_r.fwd_peak    <= '0;
      st_r.ref_peak    <= '0;
      st_r.swr_peak    <= SWR_MIN;
      st_r.running     <= 1'b0;
    end else if (commit) begin
      st_r <= st_nxt;
    end
  end

  // Result built from the updated state.
  always_comb begin
    out_nxt.forward_display    = st_nxt.fwd_shown;
    out_nxt.reflected_display  = st_nxt.ref_shown[NARROW_W-1:0];
    out_nxt.swr_display        = st_nxt.swr_shown;
    out_nxt.temp_display       = st_nxt.temp_shown[NARROW_W-1:0];
    out_nxt.forward_peak_out   = st_nxt.fwd_peak;
    out_nxt.reflected_peak_out = st_nxt.ref_peak[NARROW_W-1:0];
    out_nxt.swr_peak_out       = st_nxt.swr_peak;
    out_nxt.animating          = st_nxt.running;
    out_nxt.changed            = chg_c;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.forward_display    = out_r.forward_display;
  assign out_ch.reflected_display  = out_r.reflected_display;
  assign out_ch.swr_display        = out_r.swr_display;
  assign out_ch.temp_display       = out_r.temp_display;
  assign out_ch.forward_peak_out   = out_r.forward_peak_out;
  assign out_ch.reflected_peak_out = out_r.reflected_peak_out;
  assign out_ch.swr_peak_out       = out_r.swr_peak_out;
  assign out_ch.animating          = out_r.animating;
  assign out_ch.changed            = out_r.changed;

  // A tick that moves nothing leaves the meter at rest.
  a_tick_settles: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && s1_cmd_r == CMD_TICK && !chg_c) |=> !st_r.running)
    else $error("meter still animating after a tick that moved nothing");

  // Peak markers never fall below their targets.
  a_peak_above_target: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.fwd_peak >= st_r.fwd_target) && (st_r.ref_peak >= st_r.ref_target) &&
    (st_r.swr_peak >= st_r.swr_target))
    else $error("peak marker below its target");

  // The shown SWR stays within its range.
  a_swr_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.swr_shown >= SWR_MIN) && (st_r.swr_target >= SWR_MIN))
    else $error("SWR below its floor");

  // A result is only presented for a request that passed through the input register.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_valid_r) |=> !out_valid_r)
    else $error("result register filled without a request");

endmodule

`default_nettype wire
